@@ design/trimmed_mean_ph_converter_macros.svh @@
// Assertion macros used by the trimmed-mean pH converter RTL.
`ifndef TRIMMED_MEAN_PH_CONVERTER_MACROS_SVH
`define TRIMMED_MEAN_PH_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define TMPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition in one cycle leads to a consequence in the next.
`define TMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define TMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/tmpc_pkg.sv @@
// Shared types and constants of the trimmed-mean pH converter.
package tmpc_pkg;

    localparam int DEF_WINDOW      = 10;
    localparam int DEF_DROP        = 2;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int OFFSET_W   = 17;
    localparam int GAIN_W     = 20;
    localparam int PH_W       = 18;
    localparam int TSUM_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int GAIN_FRAC  = 16;

    localparam int PH_MAX   = 131071;
    localparam int PH_MIN   = -131072;
    localparam int TSUM_MAX = 32767;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd21340;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 20'd304000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic sum_clear;
        logic sum_add;
        logic mul;
        logic fin;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last_sample;
        logic sum_last;
    } t_stat;

endpackage

@@ design/tmpc_ctrl.sv @@
// Controller state machine of the trimmed-mean pH converter.
`include "trimmed_mean_ph_converter_macros.svh"

module tmpc_ctrl
    import tmpc_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW,
    parameter int DROP   = DEF_DROP
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam bit HAS_KEEP = (WINDOW > 2 * DROP);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.insert = 1'b1;
                    if (i_stat.last_sample) begin
                        o_cmd.sum_clear = 1'b1;
                        n_state = HAS_KEEP ? ST_SUM : ST_MUL;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.sum_add = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `TMPC_ASSERT_NEXT(a_full_leaves_idle, i_clk, i_rst_n,
        o_cmd.insert && i_stat.last_sample, r_state != ST_IDLE,
        "full window did not start a result")
    `TMPC_ASSERT_NEXT(a_sum_ends, i_clk, i_rst_n,
        (r_state == ST_SUM) && i_stat.sum_last, r_state == ST_MUL,
        "sum pass did not end at last index")
    `TMPC_ASSERT_NEXT(a_mul_then_fin, i_clk, i_rst_n,
        r_state == ST_MUL, r_state == ST_FIN, "multiply not followed by finish")
    `TMPC_ASSERT_NEXT(a_fin_then_idle, i_clk, i_rst_n,
        r_state == ST_FIN, r_state == ST_IDLE, "finish not followed by idle")
    `TMPC_ASSERT_ALWAYS(a_one_cmd, i_clk, i_rst_n,
        $onehot0({o_cmd.insert, o_cmd.sum_add, o_cmd.mul, o_cmd.fin}),
        "more than one datapath command")

endmodule

@@ design/tmpc_dp.sv @@
// Datapath of the trimmed-mean pH converter: sorted window, sum, scale, saturate.
module tmpc_dp
    import tmpc_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int DROP        = DEF_DROP,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic signed [PH_W-1:0]       o_ph_milli,
    output logic [TSUM_W-1:0]            o_trimmed_sum
);

    localparam int FILL_W    = $clog2(WINDOW);
    localparam int KEEP      = (WINDOW > 2 * DROP) ? (WINDOW - 2 * DROP) : 0;
    localparam int START_IDX = (KEEP > 0) ? DROP : 0;
    localparam int LAST_IDX  = (KEEP > 0) ? (DROP + KEEP - 1) : 0;
    localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_W    = SUM_W + GAIN_W;
    localparam int Q_W       = PROD_W - GAIN_FRAC;
    localparam int DIFF_W    = ((Q_W > OFFSET_W) ? Q_W : OFFSET_W) + 2;
    localparam int WIDE_W    = SUM_W + TSUM_W;

    localparam logic signed [DIFF_W-1:0] PH_HI = DIFF_W'(PH_MAX);
    localparam logic signed [DIFF_W-1:0] PH_LO = DIFF_W'(PH_MIN);
    localparam logic [WIDE_W-1:0]        TSUM_HI = WIDE_W'(TSUM_MAX);

    logic [SAMPLE_BITS-1:0]       r_win [WINDOW];
    logic [SAMPLE_BITS-1:0]       n_win [WINDOW];
    logic [WINDOW-1:0]            w_le;
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            r_idx;
    logic [SUM_W-1:0]             r_acc;
    logic [PROD_W-1:0]            r_prod;
    logic signed [OFFSET_W-1:0]   r_offset;
    logic [GAIN_W-1:0]            r_gain;
    logic                         r_valid;
    logic signed [PH_W-1:0]       r_ph;
    logic [TSUM_W-1:0]            r_tsum;

    logic [Q_W-1:0]               w_quot;
    logic signed [DIFF_W-1:0]     w_diff;
    logic signed [PH_W-1:0]       w_ph;
    logic [WIDE_W-1:0]            w_acc_wide;
    logic [TSUM_W-1:0]            w_tsum;

    // Sorted insert: entries at or below the new sample hold, the rest move up.
    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            assign w_le[g] = (FILL_W'(g) < r_fill) && (r_win[g] <= i_sample);
            if (g == 0) begin : g_first
                assign n_win[g] = w_le[g] ? r_win[g] : i_sample;
            end else begin : g_rest
                assign n_win[g] = w_le[g] ? r_win[g] :
                                  (w_le[g-1] ? i_sample : r_win[g-1]);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.insert) begin
            r_fill <= o_stat.last_sample ? '0 : r_fill + 1'b1;
        end
    end

    assign o_stat.last_sample = (r_fill == FILL_W'(WINDOW - 1));
    assign o_stat.sum_last    = (r_idx == FILL_W'(LAST_IDX));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clear) begin
            r_acc <= '0;
            r_idx <= FILL_W'(START_IDX);
        end else if (i_cmd.sum_add) begin
            r_acc <= r_acc + SUM_W'(r_win[r_idx]);
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_acc) * PROD_W'(r_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_gain   <= GAIN_RESET;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                REG_OFFSET: r_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_quot = r_prod[PROD_W-1:GAIN_FRAC];
        w_diff = DIFF_W'(r_offset) - $signed(DIFF_W'(w_quot));
        if (w_diff > PH_HI) begin
            w_ph = PH_W'(PH_HI);
        end else if (w_diff < PH_LO) begin
            w_ph = PH_W'(PH_LO);
        end else begin
            w_ph = w_diff[PH_W-1:0];
        end
        w_acc_wide = WIDE_W'(r_acc);
        w_tsum = (w_acc_wide > TSUM_HI) ? TSUM_HI[TSUM_W-1:0] : w_acc_wide[TSUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_ph   <= w_ph;
            r_tsum <= w_tsum;
        end
    end

    assign o_valid       = r_valid;
    assign o_ph_milli    = r_ph;
    assign o_trimmed_sum = r_tsum;

endmodule

@@ design/trimmed_mean_ph_converter.sv @@
// Top level of the trimmed-mean pH converter.
//
// Channel   Direction  Signals                                  Transfer
// sample    in         i_start, o_busy, i_sample                i_start high, o_busy low
// result    out        o_valid, o_ph_milli, o_trimmed_sum       o_valid high, one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,   i_cfg_valid and o_cfg_ready
//                      i_cfg_data
//
// A sample transfer places the sample into the sorted window at once, and
// o_busy stays low until the window is full.
// The sample that fills the window raises o_busy while the kept entries
// (KEEP = WINDOW - 2*DROP, six by default) pass through the accumulator,
// then through the gain multiplier, then through subtract and saturate.
// The result strobes on o_valid in the same cycle that o_busy falls.
// Synchronous active-low reset empties the window and restores the register
// defaults; the result side cannot stall, so a result is never held back.
module trimmed_mean_ph_converter
    import tmpc_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int DROP        = DEF_DROP,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    output logic signed [PH_W-1:0] o_ph_milli,
    output logic [TSUM_W-1:0]      o_trimmed_sum,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Registers take a write in any cycle; writes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    tmpc_ctrl #(
        .WINDOW (WINDOW),
        .DROP   (DROP)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // Hold the sorted window, sum the middle entries, scale and saturate.
    tmpc_dp #(
        .WINDOW      (WINDOW),
        .DROP        (DROP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_sample      (i_sample),
        .i_cfg_wr      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_ph_milli    (o_ph_milli),
        .o_trimmed_sum (o_trimmed_sum)
    );

endmodule

@@ test/tb_top.sv @@
// Testbench for the trimmed-mean pH converter: directed and random sample windows.
`timescale 1ns / 1ps

module tb_top;
    import tmpc_pkg::*;

    localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
    localparam int WIN_LEN       = DEF_WINDOW;
    localparam int TRIM          = DEF_DROP;
    // Busy covers the kept entries, the multiply and the finish after the filling sample; allow twice that.
    localparam int SETTLE_CYCLES = 2 * (WIN_LEN - 2 * TRIM + 2) + 4;

    // Register indexes that decode to nothing; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [CFG_DATA_W-1:0] OFFSET_MIN_DATA = 20'h10000;
    localparam logic [CFG_DATA_W-1:0] OFFSET_MAX_DATA = 20'h0FFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_MAX_DATA   = 20'hFFFFF;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_TOP      = '1;

    typedef struct {
        logic signed [PH_W-1:0] ph;
        logic [TSUM_W-1:0]      tsum;
    } t_ph_reading;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    logic [SAMPLE_W-1:0]    i_sample    = '0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_OFFSET;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_busy;
    logic                   o_valid;
    logic signed [PH_W-1:0] o_ph_milli;
    logic [TSUM_W-1:0]      o_trimmed_sum;
    logic                   o_cfg_ready;

    // Shadow of the block: window contents, fill level and calibration.
    logic [SAMPLE_W-1:0]          win_store [WIN_LEN];
    int                           win_fill;
    logic signed [OFFSET_W-1:0]   cal_offset;
    logic [GAIN_W-1:0]            cal_gain;

    t_ph_reading pending_readings [$];
    int          mismatch_count;

    trimmed_mean_ph_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .o_ph_milli    (o_ph_milli),
        .o_trimmed_sum (o_trimmed_sum),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never drains its results.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Store one sample in the shadow window; on the tenth, sort, trim and
    // queue the reading that the block should produce.
    task automatic take_sample(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] ordered [WIN_LEN];
        logic [SAMPLE_W-1:0] key;
        longint              kept_sum;
        longint              scaled;
        longint              ph_full;
        t_ph_reading         rd;
        int                  j;
        win_store[win_fill] = s;
        win_fill++;
        if (win_fill < WIN_LEN) return;
        win_fill = 0;
        ordered = win_store;
        // insertion sort, ascending
        for (int i = 1; i < WIN_LEN; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        kept_sum = 0;
        for (int i = TRIM; i < WIN_LEN - TRIM; i++) kept_sum += ordered[i];
        // exact product, truncating shift, then saturate the difference
        scaled  = (kept_sum * longint'(cal_gain)) >>> GAIN_FRAC;
        ph_full = longint'(cal_offset) - scaled;
        if (ph_full > PH_MAX) ph_full = PH_MAX;
        if (ph_full < PH_MIN) ph_full = PH_MIN;
        rd.ph   = ph_full[PH_W-1:0];
        rd.tsum = (kept_sum > TSUM_MAX) ? TSUM_W'(TSUM_MAX) : kept_sum[TSUM_W-1:0];
        pending_readings.push_back(rd);
    endtask

    // Result side: every strobe must match the oldest pending reading.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result: ph_milli=%0d trimmed_sum=%0d",
                       o_ph_milli, o_trimmed_sum);
                mismatch_count++;
            end else begin
                if (o_ph_milli !== pending_readings[0].ph) begin
                    $error("ph_milli: expected %0d, actual %0d",
                           pending_readings[0].ph, o_ph_milli);
                    mismatch_count++;
                end
                if (o_trimmed_sum !== pending_readings[0].tsum) begin
                    $error("trimmed_sum: expected %0d, actual %0d",
                           pending_readings[0].tsum, o_trimmed_sum);
                    mismatch_count++;
                end
                void'(pending_readings.pop_front());
            end
        end
    end

    // Offer one sample and hold it until the transfer; then idle for a random
    // stretch whose odds per cycle are idle_pct. i_start stays high on no gap.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int idle_pct);
        int gap;
        gap = 0;
        i_start  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_busy);
        take_sample(s);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop i_start, wait for every pending reading, then let the block settle.
    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold one register write until the transfer; i_cfg_valid stays high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_OFFSET: cal_offset = data[OFFSET_W-1:0];
            REG_GAIN:   cal_gain   = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_calibration(input logic [CFG_DATA_W-1:0] offset_data,
                                   input logic [CFG_DATA_W-1:0] gain_data);
        drain_results();
        write_reg(REG_OFFSET, offset_data);
        write_reg(REG_GAIN, gain_data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return SAMPLE_W'($urandom);
        if (roll < 80) return base + SAMPLE_W'($urandom_range(15)) - SAMPLE_W'(8);
        if (roll < 90) return ($urandom_range(1) != 0) ? SAMPLE_TOP : '0;
        return base;
    endfunction

    // Reset defaults, outliers at both ends, bit patterns and duplicates.
    task automatic test_default_calibration();
        logic [SAMPLE_W-1:0] first_win [WIN_LEN] = '{
            12'h000, 12'hFFF, 12'h555, 12'hAAA, 12'h000,
            12'hFFF, 12'h800, 12'h7FF, 12'h001, 12'hFFE};
        logic [SAMPLE_W-1:0] second_win [WIN_LEN] = '{
            12'd4000, 12'd3500, 12'd3000, 12'd2500, 12'd2000,
            12'd2000, 12'd1500, 12'd1000, 12'd500, 12'd10};
        foreach (first_win[i]) send_sample(first_win[i], 0);
        foreach (second_win[i]) send_sample(second_win[i], 0);
    endtask

    // Writes to undecoded indexes must leave the calibration untouched.
    task automatic test_spare_indexes();
        drain_results();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_2, '0);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < WIN_LEN; i++) send_sample(SAMPLE_W'($urandom), 0);
    endtask

    // Corner calibrations: negative saturation, zero gain, and the offset range.
    task automatic test_calibration_extremes();
        set_calibration(OFFSET_MIN_DATA, GAIN_MAX_DATA);
        for (int i = 0; i < WIN_LEN; i++) send_sample(SAMPLE_TOP, 0);
        set_calibration(OFFSET_MAX_DATA, '0);
        for (int i = 0; i < WIN_LEN; i++) send_sample(SAMPLE_W'($urandom), 0);
        set_calibration(OFFSET_MAX_DATA, GAIN_MAX_DATA);
        for (int i = 0; i < WIN_LEN; i++) send_sample('0, 0);
        // upper data bits set on the offset write are dropped
        set_calibration(20'hE0000 | OFFSET_MIN_DATA, 20'd1);
        for (int i = 0; i < WIN_LEN; i++) send_sample(SAMPLE_W'($urandom), 0);
    endtask

    // Random windows over several idle phases, each with its own calibration.
    task automatic test_random_phases();
        int                  idle_pct [4] = '{0, 45, 36, 0};
        int                  count;
        logic [SAMPLE_W-1:0] base;
        logic [CFG_DATA_W-1:0] off_data;
        logic [CFG_DATA_W-1:0] gain_data;
        foreach (idle_pct[p]) begin
            case ($urandom_range(3))
                0: off_data = OFFSET_MIN_DATA;
                1: off_data = OFFSET_MAX_DATA;
                default: off_data = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(3))
                0: gain_data = GAIN_MAX_DATA;
                1: gain_data = 20'd304000;
                default: gain_data = CFG_DATA_W'($urandom);
            endcase
            set_calibration(off_data, gain_data);
            count = $urandom_range(110, 85);
            base  = SAMPLE_W'($urandom);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(19) == 0) base = SAMPLE_W'($urandom);
                send_sample(pick_sample(base), idle_pct[p]);
                // hold off once mid-phase until every reading is back
                if (p == 1 && i == count / 2) drain_results();
            end
        end
    endtask

    initial begin
        win_fill       = 0;
        cal_offset     = OFFSET_RESET;
        cal_gain       = GAIN_RESET;
        mismatch_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_calibration();
        test_spare_indexes();
        test_calibration_extremes();
        test_random_phases();
        drain_results();
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tmpc_pkg.sv
design/tmpc_ctrl.sv
design/tmpc_dp.sv
design/trimmed_mean_ph_converter.sv
test/tb_top.sv
